@@ src/alu_flg_pkg.sv @@
package alu_flg_pkg;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_ADC   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_SBC   = 4'd3,
    CMD_INC   = 4'd4,
    CMD_DEC   = 4'd5,
    CMD_RLCA  = 4'd6,
    CMD_RRCA  = 4'd7,
    CMD_RLA   = 4'd8,
    CMD_RRA   = 4'd9,
    CMD_DAA   = 4'd10,
    CMD_CPL   = 4'd11,
    CMD_SCF   = 4'd12,
    CMD_CCF   = 4'd13,
    CMD_ADD16 = 4'd14,
    CMD_LDA   = 4'd15
  } cmd_e;

  // Flag register bit positions: Z N H C.
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] DaaLimit   = 8'h99;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [3:0] DaaLoLimit = 4'h9;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  operand;
    logic [15:0] wide_left;
    logic [15:0] wide_right;
  } in_t;

  typedef struct packed {
    logic [7:0]  result_value;
    logic [7:0]  accumulator_out;
    logic [15:0] wide_result;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
  } out_t;

endpackage

@@ src/cpu_alu_with_flags_unit.sv @@
// Two register stages: a beat accepted into the input register executes and its
// result is loaded into the output register once that register is free.
// Throughput: one beat per cycle unless the output stalls; the accumulator and
// flags update in the pass that loads the result register, so back-to-back ops chain.
// Reset (rst_ni low, asynchronous): accumulator and all flags clear, both stages empty.
module cpu_alu_with_flags_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  alu_flg_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output alu_flg_pkg::out_t out_data_o
);
  import alu_flg_pkg::*;

  // Pipeline control
  logic       in_valid_q;
  in_t        in_q;
  logic       out_valid_q;
  out_t       out_q;
  logic       out_free;
  logic       fire;
  logic       accept;

  // Architectural state
  logic [7:0] acc_q, acc_d;
  logic [3:0] flag_q, flag_d;

  // Per-beat results
  logic [7:0]  res_d;
  logic [15:0] wide_d;

  // The result register frees up when empty or when its beat is taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Single-pass ALU: everything is computed from the input register and
  // the current accumulator/flags.
  always_comb begin
    logic [7:0]  a;
    logic [7:0]  v;
    logic        cin;
    logic        t;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic        daa_hi;
    logic        daa_lo;
    logic [7:0]  a1;

    a      = acc_q;
    v      = in_q.operand;
    cin    = flag_q[FlagC];
    t      = 1'b0;
    sum9   = '0;
    nib5   = '0;
    sum17  = '0;
    sum13  = '0;
    daa_hi = 1'b0;
    daa_lo = 1'b0;
    a1     = acc_q;

    acc_d  = acc_q;
    flag_d = flag_q;
    res_d  = '0;
    wide_d = '0;

    case (in_q.command)
      CMD_ADD, CMD_ADC: begin
        t     = (in_q.command == CMD_ADC) ? cin : 1'b0;
        sum9  = {1'b0, a} + {1'b0, v} + {8'd0, t};
        nib5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
        acc_d = sum9[7:0];
        flag_d[FlagZ] = (sum9[7:0] == 8'd0);
        flag_d[FlagN] = 1'b0;
        flag_d[FlagH] = nib5[4];
        flag_d[FlagC] = sum9[8];
      end
      CMD_SUB, CMD_SBC: begin
        // Bit 8 / bit 4 of the wrapped difference is the borrow.
        t     = (in_q.command == CMD_SBC) ? cin : 1'b0;
        sum9  = {1'b0, a} - {1'b0, v} - {8'd0, t};
        nib5  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
        acc_d = sum9[7:0];
        flag_d[FlagZ] = (sum9[7:0] == 8'd0);
        flag_d[FlagN] = 1'b1;
        flag_d[FlagH] = nib5[4];
        flag_d[FlagC] = sum9[8];
      end
      CMD_INC: begin
        res_d = v + 8'd1;
        flag_d[FlagZ] = (res_d == 8'd0);
        flag_d[FlagN] = 1'b0;
        flag_d[FlagH] = (v[3:0] == 4'hF);
      end
      CMD_DEC: begin
        res_d = v - 8'd1;
        flag_d[FlagZ] = (res_d == 8'd0);
        flag_d[FlagN] = 1'b1;
        flag_d[FlagH] = (v[3:0] == 4'h0);
      end
      CMD_RLCA: begin
        acc_d  = {a[6:0], a[7]};
        flag_d = {3'b000, a[7]};
      end
      CMD_RRCA: begin
        acc_d  = {a[0], a[7:1]};
        flag_d = {3'b000, a[0]};
      end
      CMD_RLA: begin
        acc_d  = {a[6:0], cin};
        flag_d = {3'b000, a[7]};
      end
      CMD_RRA: begin
        acc_d  = {cin, a[7:1]};
        flag_d = {3'b000, a[0]};
      end
      CMD_DAA: begin
        if (!flag_q[FlagN]) begin
          daa_hi = cin || (a > DaaLimit);
          a1     = daa_hi ? (a + DaaHiAdj) : a;
          // Adding 0x60 leaves the low nibble alone.
          daa_lo = flag_q[FlagH] || (a[3:0] > DaaLoLimit);
          acc_d  = daa_lo ? (a1 + DaaLoAdj) : a1;
          flag_d[FlagC] = cin || daa_hi;
        end else begin
          a1    = cin ? (a - DaaHiAdj) : a;
          acc_d = flag_q[FlagH] ? (a1 - DaaLoAdj) : a1;
          flag_d[FlagC] = cin;
        end
        flag_d[FlagZ] = (acc_d == 8'd0);
        flag_d[FlagH] = 1'b0;
      end
      CMD_CPL: begin
        acc_d = ~a;
        flag_d[FlagN] = 1'b1;
        flag_d[FlagH] = 1'b1;
      end
      CMD_SCF: begin
        flag_d[FlagN] = 1'b0;
        flag_d[FlagH] = 1'b0;
        flag_d[FlagC] = 1'b1;
      end
      CMD_CCF: begin
        flag_d[FlagN] = 1'b0;
        flag_d[FlagH] = 1'b0;
        flag_d[FlagC] = ~cin;
      end
      CMD_ADD16: begin
        // Half carry from bit 11, carry from bit 15; Z untouched.
        sum17  = {1'b0, in_q.wide_left} + {1'b0, in_q.wide_right};
        sum13  = {1'b0, in_q.wide_left[11:0]} + {1'b0, in_q.wide_right[11:0]};
        wide_d = sum17[15:0];
        flag_d[FlagN] = 1'b0;
        flag_d[FlagH] = sum13[12];
        flag_d[FlagC] = sum17[16];
      end
      CMD_LDA: begin
        acc_d = v;
      end
      default: begin
        acc_d  = acc_q;
        flag_d = flag_q;
      end
    endcase

    // INC/DEC report the target register; everything else the accumulator.
    if (!(in_q.command == CMD_INC || in_q.command == CMD_DEC)) begin
      res_d = acc_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // Accumulator, flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      flag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        acc_q  <= acc_d;
        flag_q <= flag_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.result_value    <= res_d;
      out_q.accumulator_out <= acc_d;
      out_q.wide_result     <= wide_d;
      out_q.zero_flag       <= flag_d[FlagZ];
      out_q.subtract_flag   <= flag_d[FlagN];
      out_q.half_carry_flag <= flag_d[FlagH];
      out_q.carry_flag      <= flag_d[FlagC];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The pending result always mirrors the live accumulator.
  a_acc_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.accumulator_out == acc_q))
    else $error("result accumulator differs from state");

  // ... and the live flags.
  a_flag_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({out_q.zero_flag, out_q.subtract_flag,
                      out_q.half_carry_flag, out_q.carry_flag} == flag_q))
    else $error("result flags differ from state");

  // State moves only when a beat is executed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(acc_q) && $stable(flag_q)))
    else $error("state changed without an executed beat");

  // Wide sum is only nonzero for the pair add.
  a_wide_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.command != CMD_ADD16) |=> (out_q.wide_result == 16'd0))
    else $error("wide result set by a non pair-add beat");

  // INC and DEC leave the accumulator alone.
  a_incdec_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.command == CMD_INC || in_q.command == CMD_DEC))
      |=> (acc_q == $past(acc_q)))
    else $error("inc/dec modified the accumulator");

endmodule
